// ===== sv/multi_threshold_pulse_scaler_unit_assert.svh =====
// assertion macros for the multi-threshold pulse scaler
`ifndef MULTI_THRESHOLD_PULSE_SCALER_UNIT_ASSERT_SVH
`define MULTI_THRESHOLD_PULSE_SCALER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtps same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MTPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtps next-cycle check failed");

`endif

// ===== sv/mtps_pkg.sv =====
// shared types and constants for the multi-threshold pulse scaler
package mtps_pkg;

    // opcode field of an input beat
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_READOUT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_BASELINE  = 2'd0;
    localparam logic [1:0] REG_POLARITY  = 2'd1;
    localparam logic [1:0] REG_LOWEST    = 2'd2;
    localparam logic [1:0] REG_SPACING   = 2'd3;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int SPACING_W  = 10;
    localparam int VALUE_W    = 18;   // conditioned value, signed
    localparam int THRESH_W   = 18;   // ladder threshold, unsigned
    localparam int INDEX_W    = 6;
    localparam int PCOUNT_W   = 32;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [SAMPLE_W-1:0]  BASELINE_RST = 16'd0;
    localparam logic                 POLARITY_RST = 1'b0;
    localparam logic [SAMPLE_W-1:0]  LOWEST_RST   = 16'd5;
    localparam logic [SPACING_W-1:0] SPACING_RST  = 10'd5;

    // control from the sequencer to every ladder lane
    typedef struct packed {
        logic sample_en;   // plain sample, run the compare
        logic disarm_all;  // start of event
        logic clear;       // zero the counters
        logic rotate;      // readout, shift counters toward lane zero
        logic gt_prev;     // value above previous value
        logic lt_prev;     // value below previous value
    } lane_ctrl_t;

endpackage

// ===== sv/multi_threshold_pulse_scaler_unit.sv =====
// top level of the multi-threshold pulse scaler
// a sample beat is registered in the input stage, and from there updates the ladder registers
// throughput: sample and clear beats go at one beat per cycle; a readout beat
//   holds the input until all NUM_THRESHOLDS results have been emitted, one result
//   per cycle while the output is not stalled, paced by the counter rotation through lane zero
// reset: rst_n async; counters, armed flags and previous value to zero, config to reset values
module multi_threshold_pulse_scaler_unit #(
    parameter int NUM_THRESHOLDS = 64,
    parameter int COUNT_WIDTH    = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [mtps_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // [15:0] sample
    input  logic [2:0]                        s_tuser,  // [1:0] opcode, [2] start_of_event
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // [5:0] threshold_index,
                                                        // [37:6] pulse_count, rest zero
    output logic                              m_tlast
);
    import mtps_pkg::*;

    localparam int IDX_W = (NUM_THRESHOLDS > 1) ? $clog2(NUM_THRESHOLDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_THRESHOLDS - 1);

    // configuration registers
    logic [SAMPLE_W-1:0]  baseline_reg;
    logic                 polarity_reg;
    logic [SAMPLE_W-1:0]  lowest_reg;
    logic [SPACING_W-1:0] spacing_reg;

    // input stage: opcode, flag and conditioned value of the accepted beat
    logic                      a_valid_reg;
    logic [1:0]                a_op_reg;
    logic                      a_soe_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic signed [VALUE_W-1:0] diff;
    logic signed [VALUE_W-1:0] prev_reg;

    // readout sequencer and output register
    logic [IDX_W-1:0]    rd_idx_reg;
    logic                rd_last;
    logic                emit;
    logic                a_done;
    logic                in_beat;
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [PCOUNT_W-1:0] m_count_reg;
    logic                m_last_reg;

    lane_ctrl_t ctrl;
    logic [COUNT_WIDTH-1:0] lane_count [NUM_THRESHOLDS];

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= BASELINE_RST;
            polarity_reg <= POLARITY_RST;
            lowest_reg   <= LOWEST_RST;
            spacing_reg  <= SPACING_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASELINE: baseline_reg <= cfg_data[SAMPLE_W-1:0];
                REG_POLARITY: polarity_reg <= cfg_data[0];
                REG_LOWEST:   lowest_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_SPACING:  spacing_reg  <= cfg_data[SPACING_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input stage: baseline subtraction and polarity on the way in
    // ---------------------------------------------------------------
    assign diff = $signed({2'b00, s_tdata}) - $signed({2'b00, baseline_reg});
    assign value_next = polarity_reg ? -diff : diff;

    // the stage frees itself at once unless a readout is still running
    assign emit    = a_valid_reg && (a_op_reg == OP_READOUT) && (!m_valid_reg || m_tready);
    assign rd_last = (rd_idx_reg == LAST_IDX);
    assign a_done  = (a_op_reg != OP_READOUT) || (emit && rd_last);
    assign s_tready = !a_valid_reg || a_done;
    assign in_beat  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            a_op_reg    <= s_tuser[1:0];
            a_soe_reg   <= s_tuser[2];
            a_value_reg <= value_next;
        end
    end

    // previous value follows every sample beat, start of event included
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (a_valid_reg && (a_op_reg == OP_SAMPLE))
        begin
            prev_reg <= a_value_reg;
        end
    end

    // ---------------------------------------------------------------
    // lane control, shared compare against the previous value
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl.sample_en  = a_valid_reg && (a_op_reg == OP_SAMPLE) && !a_soe_reg;
        ctrl.disarm_all = a_valid_reg && (a_op_reg == OP_SAMPLE) && a_soe_reg;
        ctrl.clear      = a_valid_reg && (a_op_reg == OP_CLEAR);
        ctrl.rotate     = emit;
        ctrl.gt_prev    = a_value_reg > prev_reg;
        ctrl.lt_prev    = a_value_reg < prev_reg;
    end

    // ---------------------------------------------------------------
    // ladder lanes; readout rotates the counters through lane zero so a
    // full pass leaves every counter back in its own lane
    // ---------------------------------------------------------------
    for (genvar j = 0; j < NUM_THRESHOLDS; j++)
    begin : g_lane
        mtps_lane #(
            .LANE_IDX    (j),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .value    (a_value_reg),
            .lowest   (lowest_reg),
            .spacing  (spacing_reg),
            .shift_in (lane_count[(j + 1) % NUM_THRESHOLDS]),
            .count    (lane_count[j])
        );
    end

    // ---------------------------------------------------------------
    // readout index and result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                rd_idx_reg <= rd_last ? '0 : rd_idx_reg + IDX_W'(1);
            end
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_index_reg <= INDEX_W'(rd_idx_reg);
            m_count_reg <= PCOUNT_W'(lane_count[0]);
            m_last_reg  <= rd_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_index_reg};
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
`include "multi_threshold_pulse_scaler_unit_assert.svh"

    // the last beat of a run carries the top ladder entry
    `MTPS_ASSERT_IMP(a_last_index, m_valid_reg && m_last_reg, m_index_reg == INDEX_W'(LAST_IDX))
    // no new beat enters while a readout run is unfinished
    `MTPS_ASSERT_IMP(a_hold_readout, a_valid_reg && (a_op_reg == OP_READOUT) && !(emit && rd_last), !s_tready)
    // the readout index only moves during a readout run
    `MTPS_ASSERT_IMP(a_idx_idle, rd_idx_reg != '0, a_valid_reg && (a_op_reg == OP_READOUT))
    // a rotation step always lands in the result register
    `MTPS_ASSERT_NXT(a_emit_shows, emit, m_valid_reg)

endmodule

// ===== sv/mtps_lane.sv =====
// one ladder entry: threshold, armed flag and saturating pulse counter
module mtps_lane #(
    parameter int LANE_IDX    = 0,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mtps_pkg::lane_ctrl_t               ctrl,
    input  logic signed [mtps_pkg::VALUE_W-1:0] value,
    input  logic [mtps_pkg::SAMPLE_W-1:0]      lowest,
    input  logic [mtps_pkg::SPACING_W-1:0]     spacing,
    input  logic [COUNT_WIDTH-1:0]             shift_in,
    output logic [COUNT_WIDTH-1:0]             count
);
    import mtps_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [THRESH_W-1:0]    thresh_reg;
    logic [THRESH_W-1:0]    thresh_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   above;
    logic                   below;

    // threshold kept registered; config only changes while idle is the user's duty, the block does not enforce it
    assign thresh_next = THRESH_W'(lowest)
                       + THRESH_W'(LANE_IDX) * THRESH_W'(spacing);

    assign above = $signed({value[VALUE_W-1], value}) > $signed({1'b0, thresh_reg});
    assign below = $signed({value[VALUE_W-1], value}) < $signed({1'b0, thresh_reg});

    always_comb
    begin
        armed_next = armed_reg;
        count_next = count_reg;
        if (ctrl.disarm_all)
        begin
            armed_next = 1'b0;
        end
        else if (ctrl.sample_en)
        begin
            if (!armed_reg)
            begin
                if (above && ctrl.gt_prev)
                begin
                    armed_next = 1'b1;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            else if (below && ctrl.lt_prev)
            begin
                armed_next = 1'b0;
            end
        end
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.rotate)
        begin
            count_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            count_reg  <= '0;
            thresh_reg <= '0;
        end
        else
        begin
            armed_reg  <= armed_next;
            count_reg  <= count_next;
            thresh_reg <= thresh_next;
        end
    end

    assign count = count_reg;

endmodule
